// ===== hw/rtl/irsd_pkg.sv =====
// Shared types, register indexes, codes and coil table for the IR stepper drive.
`default_nettype none
package irsd_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_LEADER_MIN    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ONE_MIN       = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SPACE_TIMEOUT = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_RELEASE_LIMIT = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_FORWARD_CODE  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_LEFT_CODE     = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_RIGHT_CODE    = 3'd6;

  // Register reset values
  localparam logic [15:0] LEADER_MIN_RST    = 16'd750;
  localparam logic [15:0] ONE_MIN_RST       = 16'd50;
  localparam logic [15:0] SPACE_TIMEOUT_RST = 16'd5000;
  localparam logic [15:0] RELEASE_LIMIT_RST = 16'd5000;
  localparam logic [31:0] FORWARD_CODE_RST  = 32'h00FF_629D;
  localparam logic [31:0] LEFT_CODE_RST     = 32'h00FF_22DD;
  localparam logic [31:0] RIGHT_CODE_RST    = 32'h00FF_C23D;

  // Drive modes
  localparam logic [1:0] MODE_STOP    = 2'd0;
  localparam logic [1:0] MODE_RIGHT   = 2'd1;
  localparam logic [1:0] MODE_LEFT    = 2'd2;
  localparam logic [1:0] MODE_FORWARD = 2'd3;

  // Indicator patterns per command
  localparam logic [3:0] IND_OFF     = 4'd0;
  localparam logic [3:0] IND_LEFT    = 4'd1;
  localparam logic [3:0] IND_RIGHT   = 4'd2;
  localparam logic [3:0] IND_FORWARD = 4'd3;

  // Frame length in bits
  localparam logic [5:0] FRAME_BITS = 6'd32;

  // Stream payload widths
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 48;

  typedef struct packed {
    logic [15:0] leader_min;
    logic [15:0] one_min;
    logic [15:0] space_timeout;
    logic [15:0] release_limit;
    logic [31:0] forward_code;
    logic [31:0] left_code;
    logic [31:0] right_code;
  } cfg_t;

  // Decoder result for one sample (next values of the command state)
  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  indicator;
    logic        done;
    logic [31:0] word;
  } dec_res_t;

  // Full-step coil pattern for a phase index
  function automatic logic [3:0] coil_pattern(input logic [1:0] idx);
    logic [3:0] pat;
    case (idx)
      2'd0:    pat = 4'd3;
      2'd1:    pat = 4'd6;
      2'd2:    pat = 4'd12;
      default: pat = 4'd9;
    endcase
    return pat;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/irsd_decode.sv =====
// NEC-style frame decoder with command match and release timeout.
`default_nettype none
module irsd_decode import irsd_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     en,
  input  wire logic     ir_level,
  input  wire cfg_t     cfg,
  output dec_res_t      res
);

  localparam int unsigned CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_LEADER = 5'b00010,
    PH_LSPACE = 5'b00100,
    PH_MARK   = 5'b01000,
    PH_SPACE  = 5'b10000
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] dur_r, dur_nxt, dur_inc;
  logic [COUNT_WIDTH-1:0] rel_r, rel_nxt, rel_inc;
  logic [5:0]             bidx_r, bidx_nxt, bidx_inc;
  logic [31:0]            shift_r, shift_nxt, shift_in;
  logic [1:0]             mode_r, mode_nxt;
  logic [3:0]             ind_r, ind_nxt;
  logic [31:0]            word_r, word_nxt;
  logic                   done;
  logic                   dur_gt_leader, dur_inc_gt_tmo, rel_inc_gt_lim, bit_one;

  // Saturating counters and threshold compares
  assign dur_inc  = (dur_r == '1) ? dur_r : dur_r + CNT_ONE;
  assign rel_inc  = (rel_r == '1) ? rel_r : rel_r + CNT_ONE;
  assign bidx_inc = bidx_r + 6'd1;
  assign bit_one  = CMP_W'(dur_r) > CMP_W'(cfg.one_min);
  assign shift_in = {shift_r[30:0], bit_one};
  assign dur_gt_leader  = CMP_W'(dur_r) > CMP_W'(cfg.leader_min);
  assign dur_inc_gt_tmo = CMP_W'(dur_inc) > CMP_W'(cfg.space_timeout);
  assign rel_inc_gt_lim = CMP_W'(rel_inc) > CMP_W'(cfg.release_limit);

  // Receive state machine
  always_comb begin
    phase_nxt = phase_r;
    dur_nxt   = dur_r;
    rel_nxt   = rel_r;
    bidx_nxt  = bidx_r;
    shift_nxt = shift_r;
    mode_nxt  = mode_r;
    ind_nxt   = ind_r;
    word_nxt  = word_r;
    done      = 1'b0;
    case (phase_r)
      PH_LEADER: begin
        if (!ir_level) begin
          dur_nxt = dur_inc;
        end else if (dur_gt_leader) begin
          phase_nxt = PH_LSPACE;
          bidx_nxt  = '0;
          shift_nxt = '0;
          dur_nxt   = '0;
        end else begin
          phase_nxt = PH_IDLE;
          rel_nxt   = '0;
          dur_nxt   = '0;
        end
      end
      PH_LSPACE: begin
        if (!ir_level) begin
          phase_nxt = PH_MARK;
          dur_nxt   = CNT_ONE;
        end
      end
      PH_MARK: begin
        if (!ir_level) begin
          dur_nxt = dur_inc;
        end else if (dur_gt_leader) begin
          // over-long mark: treat as a new leader
          phase_nxt = PH_LSPACE;
          bidx_nxt  = '0;
          shift_nxt = '0;
          dur_nxt   = '0;
        end else if (cfg.space_timeout == '0) begin
          // first space sample already beyond timeout
          phase_nxt = PH_IDLE;
          rel_nxt   = '0;
          dur_nxt   = '0;
        end else begin
          phase_nxt = PH_SPACE;
          dur_nxt   = CNT_ONE;
        end
      end
      PH_SPACE: begin
        if (ir_level) begin
          if (dur_inc_gt_tmo) begin
            phase_nxt = PH_IDLE;
            rel_nxt   = '0;
            dur_nxt   = '0;
          end else begin
            dur_nxt = dur_inc;
          end
        end else begin
          shift_nxt = shift_in;
          dur_nxt   = CNT_ONE;
          if (bidx_inc >= FRAME_BITS) begin
            // frame complete; this low sample opens the next leader
            done      = 1'b1;
            word_nxt  = shift_in;
            bidx_nxt  = '0;
            rel_nxt   = '0;
            phase_nxt = PH_LEADER;
            if (shift_in == cfg.forward_code) begin
              mode_nxt = MODE_FORWARD;
              ind_nxt  = IND_FORWARD;
            end else if (shift_in == cfg.left_code) begin
              mode_nxt = MODE_LEFT;
              ind_nxt  = IND_LEFT;
            end else if (shift_in == cfg.right_code) begin
              mode_nxt = MODE_RIGHT;
              ind_nxt  = IND_RIGHT;
            end
          end else begin
            bidx_nxt  = bidx_inc;
            phase_nxt = PH_MARK;
          end
        end
      end
      default: begin
        // idle, and any stray code
        phase_nxt = PH_IDLE;
        if (ir_level) begin
          rel_nxt = rel_inc;
          if (rel_inc_gt_lim) begin
            mode_nxt = MODE_STOP;
            ind_nxt  = IND_OFF;
          end
        end else begin
          rel_nxt   = '0;
          phase_nxt = PH_LEADER;
          dur_nxt   = CNT_ONE;
        end
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      dur_r   <= '0;
      rel_r   <= '0;
      bidx_r  <= '0;
      shift_r <= '0;
      mode_r  <= MODE_STOP;
      ind_r   <= IND_OFF;
      word_r  <= '0;
    end else if (en) begin
      phase_r <= phase_nxt;
      dur_r   <= dur_nxt;
      rel_r   <= rel_nxt;
      bidx_r  <= bidx_nxt;
      shift_r <= shift_nxt;
      mode_r  <= mode_nxt;
      ind_r   <= ind_nxt;
      word_r  <= word_nxt;
    end
  end

  assign res = '{mode: mode_nxt, indicator: ind_nxt, done: done, word: word_nxt};

endmodule
`default_nettype wire

// ===== hw/rtl/irsd_stepper.sv =====
// Two full-step phase counters and coil pin register.
`default_nettype none
module irsd_stepper import irsd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       en,
  input  wire logic       step_tick,
  input  wire logic [1:0] mode,
  output logic      [7:0] pins_nxt
);

  logic [1:0] left_r, left_nxt, right_r, right_nxt;
  logic [7:0] pins_r;
  logic       move;

  assign move = step_tick && (mode != MODE_STOP);

  // Phase direction per mode
  always_comb begin
    left_nxt  = left_r;
    right_nxt = right_r;
    if (move) begin
      case (mode)
        MODE_RIGHT: begin
          left_nxt  = left_r - 2'd1;
          right_nxt = right_r - 2'd1;
        end
        MODE_LEFT: begin
          left_nxt  = left_r + 2'd1;
          right_nxt = right_r + 2'd1;
        end
        default: begin
          left_nxt  = left_r - 2'd1;
          right_nxt = right_r + 2'd1;
        end
      endcase
    end
  end

  // Pins hold unless the motors move
  assign pins_nxt = move ? {coil_pattern(right_nxt), coil_pattern(left_nxt)} : pins_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= '0;
      right_r <= '0;
      pins_r  <= '0;
    end else if (en) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
      pins_r  <= pins_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ir_remote_stepper_drive_core.sv =====
// An accepted item passes the input register, then the output register (out_tvalid).
// Throughput: one item per cycle unless stalled; input register feeds decoder and
// stepper logic, whose result lands in the output register, so both stages advance
// together. Stalls on out_tready back up into the input register and then in_tready.
// Reset (rst_n low, synchronous): registers to reset values, decoder idle,
// mode stop, phase counters and pins zero, no items in flight.
`default_nettype none
module ir_remote_stepper_drive_core import irsd_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [0] ir_level, [1] step_tick
  // result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_DATA_W-1:0] out_tdata,  // [7:0] motor_pins, [11:8] indicator,
                                                 // [13:12] drive_mode, [14] frame_done,
                                                 // [46:15] frame_word
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [31:0]           cfg_wdata
);

  cfg_t            cfg_r;
  logic            s1_v_r, s1_ir_r, s1_tick_r;
  logic            out_v_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic            adv, en;
  dec_res_t        dec_res;
  logic [7:0]      pins_nxt;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.leader_min    <= LEADER_MIN_RST;
      cfg_r.one_min       <= ONE_MIN_RST;
      cfg_r.space_timeout <= SPACE_TIMEOUT_RST;
      cfg_r.release_limit <= RELEASE_LIMIT_RST;
      cfg_r.forward_code  <= FORWARD_CODE_RST;
      cfg_r.left_code     <= LEFT_CODE_RST;
      cfg_r.right_code    <= RIGHT_CODE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_LEADER_MIN:    cfg_r.leader_min    <= cfg_wdata[15:0];
        REG_ONE_MIN:       cfg_r.one_min       <= cfg_wdata[15:0];
        REG_SPACE_TIMEOUT: cfg_r.space_timeout <= cfg_wdata[15:0];
        REG_RELEASE_LIMIT: cfg_r.release_limit <= cfg_wdata[15:0];
        REG_FORWARD_CODE:  cfg_r.forward_code  <= cfg_wdata;
        REG_LEFT_CODE:     cfg_r.left_code     <= cfg_wdata;
        REG_RIGHT_CODE:    cfg_r.right_code    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pipeline handshake: the stage pair moves when the output slot frees
  assign adv       = !out_v_r || out_tready;
  assign in_tready = !s1_v_r || adv;
  assign en        = s1_v_r && adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_ir_r   <= in_tdata[0];
      s1_tick_r <= in_tdata[1];
    end
  end

  irsd_decode #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .ir_level (s1_ir_r),
    .cfg      (cfg_r),
    .res      (dec_res)
  );

  irsd_stepper u_stepper (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .step_tick (s1_tick_r),
    .mode      (dec_res.mode),
    .pins_nxt  (pins_nxt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {1'b0, dec_res.word, dec_res.done, dec_res.mode,
                     dec_res.indicator, pins_nxt};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  // Checks
  a_en_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    en |=> out_v_r)
    else $error("processed item did not reach the output register");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !adv) |=> s1_v_r)
    else $error("input register dropped an item during a stall");

  a_ready_means_room: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_v_r && out_v_r))
    else $error("input blocked without both stages full");

  a_mode_matches_ind: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> ((out_data_r[13:12] == MODE_STOP) == (out_data_r[11:8] == IND_OFF)))
    else $error("drive mode and indicator disagree");

endmodule
`default_nettype wire
